// File: design/vbm3d_pkg.sv
// vbm3d_pkg: sizes, register indexes and voxel codes for the 3d boundary marker
// used by voxel_boundary_mark_3d; depends on nothing else

package vbm3d_pkg;

  // largest volume plane the delay memories are sized for
  localparam int MAX_ROWS    = 128;
  localparam int MAX_COLUMNS = 128;

  // item field widths
  localparam int VOXEL_W = 8;
  localparam int SLICE_W = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // widths of clamped sizes and counts
  localparam int ROWS_W  = $clog2(MAX_ROWS + 1);
  localparam int COLS_W  = $clog2(MAX_COLUMNS + 1);
  localparam int PLANE_W = $clog2(MAX_ROWS * MAX_COLUMNS + 1);
  localparam int TOTAL_W = PLANE_W + SLICE_W;
  localparam int LAG_W   = PLANE_W + 1;

  // plane delay memory and row delay memory
  localparam int PLANE_DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int PLANE_AW    = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1;
  localparam int ROW_DEPTH   = MAX_ROWS;
  localparam int ROW_AW      = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;

  // input held off after reset or a register write until the settle count runs out
  localparam int SETTLE_CYCLES = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_COUNT  = 2'd2;

  // register reset values
  localparam logic [7:0]         ROW_COUNT_RST    = 8'd128;
  localparam logic [7:0]         COLUMN_COUNT_RST = 8'd128;
  localparam logic [SLICE_W-1:0] SLICE_COUNT_RST  = 16'd1;

  // voxel codes
  localparam logic [VOXEL_W-1:0] VOXEL_BACKGROUND = 8'd0;
  localparam logic [VOXEL_W-1:0] VOXEL_OBJECT     = 8'd1;
  localparam logic [VOXEL_W-1:0] VOXEL_MARK       = 8'd255;

endpackage

// File: design/voxel_boundary_mark_3d.sv
// voxel_boundary_mark_3d: 6-connected boundary marking of a labeled voxel stream
// depends on vbm3d_pkg for sizes, register indexes and voxel codes
//
// throughput: one item per cycle when not held off or stalled, set by the single
// read/write port of each delay memory; a result is decided as the item one plane later
// (or the flush) is taken; reset: counters clear, registers take 128/128/1, input waits
// out the settle hold, as after each register write; delay memories are never cleared

module voxel_boundary_mark_3d (
  input  logic                           clk,
  input  logic                           rst,
  // input items
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [vbm3d_pkg::VOXEL_W-1:0]  s_axis_tdata,   // [7:0] voxel_value
  input  logic                           s_axis_tuser,   // [0] flush
  // result items
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [vbm3d_pkg::VOXEL_W-1:0]  m_axis_tdata,   // [7:0] out_value
  output logic                           m_axis_tlast,   // last_voxel
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vbm3d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vbm3d_pkg::CFG_W-1:0]    cfg_data
);

  localparam int ROWS_W   = vbm3d_pkg::ROWS_W;
  localparam int COLS_W   = vbm3d_pkg::COLS_W;
  localparam int PLANE_W  = vbm3d_pkg::PLANE_W;
  localparam int TOTAL_W  = vbm3d_pkg::TOTAL_W;
  localparam int LAG_W    = vbm3d_pkg::LAG_W;
  localparam int SLICE_W  = vbm3d_pkg::SLICE_W;
  localparam int VOXEL_W  = vbm3d_pkg::VOXEL_W;
  localparam int PLANE_AW = vbm3d_pkg::PLANE_AW;
  localparam int ROW_AW   = vbm3d_pkg::ROW_AW;

  // which tap holds the voxel being decided
  typedef enum logic [1:0] {
    CTR_NEWEST,
    CTR_TAP_A,
    CTR_TAP_B,
    CTR_CENTER
  } center_sel_t;

  // raw registers
  logic [7:0]         row_count;
  logic [7:0]         column_count;
  logic [SLICE_W-1:0] slice_count;
  logic [1:0]         settle;

  // derived sizes, stage one
  logic [ROWS_W-1:0]  rows_c;
  logic [COLS_W-1:0]  cols_c;
  logic [SLICE_W-1:0] slices_c;
  logic [ROWS_W-1:0]  rows_q;
  logic [COLS_W-1:0]  cols_q;
  logic [SLICE_W-1:0] slices_q;
  logic [PLANE_W-1:0] plane_q;

  // derived sizes, stage two
  logic [TOTAL_W-1:0] total;
  logic [PLANE_W-1:0] plane;
  logic [ROWS_W-1:0]  rows_last;
  logic [COLS_W-1:0]  cols_last;
  logic [SLICE_W-1:0] slices_last;
  logic [PLANE_W-1:0] la_val;
  logic [ROWS_W-1:0]  lb_val;
  logic [PLANE_AW-1:0] la_last;
  logic [ROW_AW-1:0]  lb_last;
  logic               la_zero;
  logic               lb_zero;
  center_sel_t        ctr_sel_c;
  center_sel_t        ctr_sel;

  // position tracking
  logic [TOTAL_W-1:0] in_cnt;
  logic               in_done;
  logic               out_done;
  logic [LAG_W-1:0]   lag;
  logic [ROWS_W-1:0]  pos_i;
  logic [COLS_W-1:0]  pos_j;
  logic [SLICE_W-1:0] pos_k;

  // item control
  logic               accept;
  logic               restart;
  logic               in_full;
  logic               shift;
  logic               wrote;
  logic [TOTAL_W-1:0] in_cnt_next;
  logic               in_done_next;
  logic [LAG_W-1:0]   lag_next;
  logic               emit;
  logic               is_last;
  logic               is_edge;

  // delay line
  logic [VOXEL_W-1:0] newest;
  logic [VOXEL_W-1:0] center;
  logic [VOXEL_W-1:0] prev;
  logic [VOXEL_W-1:0] by_a;
  logic [VOXEL_W-1:0] by_b;
  logic [VOXEL_W-1:0] by_c;
  logic [VOXEL_W-1:0] by_d;
  logic [VOXEL_W-1:0] tap_a;
  logic [VOXEL_W-1:0] tap_b;
  logic [VOXEL_W-1:0] tap_c;
  logic [VOXEL_W-1:0] tap_d;
  logic [2*VOXEL_W-1:0] plane_mem [vbm3d_pkg::PLANE_DEPTH];
  logic [2*VOXEL_W-1:0] row_mem [vbm3d_pkg::ROW_DEPTH];
  logic [2*VOXEL_W-1:0] plane_q_rd;
  logic [2*VOXEL_W-1:0] row_q_rd;
  logic [PLANE_AW-1:0]  plane_ptr;
  logic [ROW_AW-1:0]    row_ptr;

  // decision stage and output
  logic               a_valid;
  logic               a_last;
  logic               a_edge;
  logic               a_move;
  logic [VOXEL_W-1:0] v_sel;
  logic               nb_zero;
  logic [VOXEL_W-1:0] res;

  assign cfg_ready = 1'b1;

  // register writes and the hold-off after them
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= vbm3d_pkg::ROW_COUNT_RST;
      column_count <= vbm3d_pkg::COLUMN_COUNT_RST;
      slice_count  <= vbm3d_pkg::SLICE_COUNT_RST;
      settle       <= 2'(vbm3d_pkg::SETTLE_CYCLES);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vbm3d_pkg::CFG_ROW_COUNT:    row_count    <= cfg_data[7:0];
        vbm3d_pkg::CFG_COLUMN_COUNT: column_count <= cfg_data[7:0];
        vbm3d_pkg::CFG_SLICE_COUNT:  slice_count  <= cfg_data;
        default: ;
      endcase
      settle <= 2'(vbm3d_pkg::SETTLE_CYCLES);
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  // clamp sizes to their legal ranges
  always_comb begin
    if (row_count == 8'd0) rows_c = ROWS_W'(1);
    else if (32'(row_count) > vbm3d_pkg::MAX_ROWS) rows_c = ROWS_W'(vbm3d_pkg::MAX_ROWS);
    else rows_c = ROWS_W'(row_count);
    if (column_count == 8'd0) cols_c = COLS_W'(1);
    else if (32'(column_count) > vbm3d_pkg::MAX_COLUMNS) begin
      cols_c = COLS_W'(vbm3d_pkg::MAX_COLUMNS);
    end else cols_c = COLS_W'(column_count);
    slices_c = (slice_count == '0) ? SLICE_W'(1) : slice_count;
  end

  // stage one: plane size
  always_ff @(posedge clk) begin
    rows_q   <= rows_c;
    cols_q   <= cols_c;
    slices_q <= slices_c;
    plane_q  <= PLANE_W'(rows_c * cols_c);
  end

  // segment lengths: plane ring and row ring; degenerate shapes empty one or both rings
  always_comb begin
    priority if (rows_q >= ROWS_W'(2) && cols_q >= COLS_W'(2)) begin
      la_val = plane_q - PLANE_W'(rows_q) - PLANE_W'(1);
      lb_val = rows_q - ROWS_W'(2);
    end else if (plane_q >= PLANE_W'(3)) begin
      la_val = plane_q - PLANE_W'(3);
      lb_val = '0;
    end else begin
      la_val = '0;
      lb_val = '0;
    end
  end

  // center tap: one plane back, or one voxel less for a single-slice volume
  always_comb begin
    priority if (plane_q >= PLANE_W'(3)) begin
      ctr_sel_c = (slices_q == SLICE_W'(1)) ? CTR_TAP_B : CTR_CENTER;
    end else if (plane_q == PLANE_W'(2)) begin
      ctr_sel_c = (slices_q == SLICE_W'(1)) ? CTR_TAP_A : CTR_TAP_B;
    end else begin
      ctr_sel_c = (slices_q == SLICE_W'(1)) ? CTR_NEWEST : CTR_TAP_A;
    end
  end

  // stage two: volume size and ring controls
  always_ff @(posedge clk) begin
    total       <= TOTAL_W'(plane_q * slices_q);
    plane       <= plane_q;
    rows_last   <= rows_q - ROWS_W'(1);
    cols_last   <= cols_q - COLS_W'(1);
    slices_last <= slices_q - SLICE_W'(1);
    la_zero     <= (la_val == '0);
    lb_zero     <= (lb_val == '0);
    la_last     <= PLANE_AW'(la_val - PLANE_W'(1));
    lb_last     <= ROW_AW'(lb_val - ROWS_W'(1));
    ctr_sel     <= ctr_sel_c;
  end

  // item acceptance and volume bookkeeping
  assign a_move        = a_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = (settle == 2'd0) && (!a_valid || a_move);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign restart       = in_done && out_done;
  assign in_full       = in_done && !out_done;
  assign shift         = accept && (in_full || !s_axis_tuser);
  assign wrote         = accept && !in_full && !s_axis_tuser;

  always_comb begin
    in_cnt_next  = (restart ? '0 : in_cnt) + TOTAL_W'(wrote);
    in_done_next = (in_cnt_next >= total);
    lag_next     = lag + LAG_W'(wrote);
    emit         = shift && (lag_next != '0) &&
                   (in_done_next || lag_next > LAG_W'(plane));
    is_last      = (pos_i == rows_last) && (pos_j == cols_last) && (pos_k >= slices_last);
    is_edge      = (pos_i == '0) || (pos_i == rows_last) || (pos_j == '0) ||
                   (pos_j == cols_last) || (pos_k == '0) || (pos_k >= slices_last);
  end

  // positions: input count, lag and output coordinates
  always_ff @(posedge clk) begin
    if (rst) begin
      in_cnt   <= '0;
      in_done  <= 1'b0;
      out_done <= 1'b0;
      lag      <= '0;
      pos_i    <= '0;
      pos_j    <= '0;
      pos_k    <= '0;
    end else if (accept) begin
      in_cnt  <= in_cnt_next;
      in_done <= in_done_next;
      if (restart) out_done <= 1'b0;
      if (emit) begin
        lag <= lag_next - LAG_W'(1);
        if (is_last) out_done <= 1'b1;
        if (pos_i == rows_last) begin
          pos_i <= '0;
          if (pos_j == cols_last) begin
            pos_j <= '0;
            pos_k <= is_last ? '0 : pos_k + SLICE_W'(1);
          end else begin
            pos_j <= pos_j + COLS_W'(1);
          end
        end else begin
          pos_i <= pos_i + ROWS_W'(1);
        end
      end else begin
        lag <= lag_next;
      end
    end
  end

  // taps: memory read data, or the bypass stage when a segment is empty
  assign tap_a = la_zero ? by_a : plane_q_rd[VOXEL_W-1:0];
  assign tap_d = la_zero ? by_d : plane_q_rd[2*VOXEL_W-1:VOXEL_W];
  assign tap_b = lb_zero ? by_b : row_q_rd[VOXEL_W-1:0];
  assign tap_c = lb_zero ? by_c : row_q_rd[2*VOXEL_W-1:VOXEL_W];

  // register taps of the delay line
  always_ff @(posedge clk) begin
    if (shift) begin
      newest <= s_axis_tdata;
      center <= tap_b;
      prev   <= center;
      by_a   <= newest;
      by_d   <= tap_c;
      by_b   <= tap_a;
      by_c   <= prev;
    end
  end

  // plane memory: two rings of equal length, read before write
  always_ff @(posedge clk) begin
    if (shift) begin
      plane_q_rd          <= plane_mem[plane_ptr];
      plane_mem[plane_ptr] <= {tap_c, newest};
    end
  end

  // row memory: two rings of equal length, read before write
  always_ff @(posedge clk) begin
    if (shift) begin
      row_q_rd         <= row_mem[row_ptr];
      row_mem[row_ptr] <= {prev, tap_a};
    end
  end

  // ring pointers restart on every register write
  always_ff @(posedge clk) begin
    if (rst || cfg_valid) begin
      plane_ptr <= '0;
      row_ptr   <= '0;
    end else if (shift) begin
      plane_ptr <= (la_zero || plane_ptr >= la_last) ? '0 : plane_ptr + PLANE_AW'(1);
      row_ptr   <= (lb_zero || row_ptr >= lb_last) ? '0 : row_ptr + ROW_AW'(1);
    end
  end

  // boundary decision from the registered taps
  always_comb begin
    unique case (ctr_sel)
      CTR_NEWEST: v_sel = newest;
      CTR_TAP_A:  v_sel = tap_a;
      CTR_TAP_B:  v_sel = tap_b;
      CTR_CENTER: v_sel = center;
      default:    v_sel = center;
    endcase
    nb_zero = (tap_b == vbm3d_pkg::VOXEL_BACKGROUND) || (prev == vbm3d_pkg::VOXEL_BACKGROUND) ||
              (tap_a == vbm3d_pkg::VOXEL_BACKGROUND) || (tap_c == vbm3d_pkg::VOXEL_BACKGROUND) ||
              (newest == vbm3d_pkg::VOXEL_BACKGROUND) ||
              (tap_d == vbm3d_pkg::VOXEL_BACKGROUND);
    res = (v_sel == vbm3d_pkg::VOXEL_OBJECT && (a_edge || nb_zero)) ?
          vbm3d_pkg::VOXEL_MARK : v_sel;
  end

  // decision stage holds the result flags until the output register frees
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= emit;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_last <= is_last;
      a_edge <= is_edge;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (a_move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      m_axis_tdata <= res;
      m_axis_tlast <= a_last;
    end
  end

endmodule
